FILE: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker module.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is low.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/core/npt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_pkg
// Types and constants of the near point thinning block.
// ----------------------------------------------------------------------------
package npt_pkg;

    localparam int WORD_W = 32;
    localparam int SPAN_W = WORD_W + 1;
    localparam int RATIO_W = 16;
    localparam int PROD_W = SPAN_W + RATIO_W + 1;
    localparam int DIM_W = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int NUM_COORDS = 4;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DROP_DUP = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIMS = 2'd2;

    localparam logic CFG_DROP_DUP_RST = 1'b1;
    localparam logic [RATIO_W-1:0] CFG_RATIO_RST = 16'd512;
    localparam logic [DIM_W-1:0] CFG_DIMS_RST = 3'd3;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic signed [SPAN_W-1:0] t_span;
    typedef logic signed [PROD_W-1:0] t_prod;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_START,
        ST_CHECK,
        ST_RD_P,
        ST_RD_N,
        ST_RD_I,
        ST_RD_I1,
        ST_RD_PM,
        ST_CAP_PM,
        ST_DECIDE,
        ST_MV_RD,
        ST_MV_WR,
        ST_FINISH,
        ST_EM_RD,
        ST_EM_CAP,
        ST_EM_OUT
    } t_npt_state;

endpackage

FILE: rtl/core/npt_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_in_if
// Input point channel: valid/ready with one point and its final mark.
// ----------------------------------------------------------------------------
interface npt_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] abscissa;
    logic [31:0] coord_a;
    logic [31:0] coord_b;
    logic [31:0] coord_c;
    logic [31:0] coord_d;
    logic        final_point;

    modport source (
        output valid, abscissa, coord_a, coord_b, coord_c, coord_d, final_point,
        input  ready
    );
    modport sink (
        input  valid, abscissa, coord_a, coord_b, coord_c, coord_d, final_point,
        output ready
    );
endinterface

FILE: rtl/core/npt_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_out_if
// Output channel: valid/ready with one kept point and its status flags.
// ----------------------------------------------------------------------------
interface npt_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] kept_abscissa;
    logic [31:0] kept_a;
    logic [31:0] kept_b;
    logic [31:0] kept_c;
    logic [31:0] kept_d;
    logic        end_of_run;
    logic        overflowed;

    modport source (
        output valid, kept_abscissa, kept_a, kept_b, kept_c, kept_d,
               end_of_run, overflowed,
        input  ready
    );
    modport sink (
        input  valid, kept_abscissa, kept_a, kept_b, kept_c, kept_d,
               end_of_run, overflowed,
        output ready
    );
endinterface

FILE: rtl/core/near_point_thinning.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// near_point_thinning
// Stores a point sequence, thins points lying too near a neighbor and
// streams the kept points out after the final point.
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  i_in_ch   in   valid/ready    abscissa, coord_a..d, final_point
//  o_out_ch  out  valid/ready    kept_abscissa, kept_a..d, end_of_run, overflowed
//  cfg       in   i_cfg_we       i_cfg_idx, i_cfg_data
//
//  Loading takes one item a cycle. The final item starts thinning: each scan
//  step makes 5 reads of the single memory port and two products of the
//  shared multiplier, plus a read and a write for a point move. Emission
//  reads, captures and offers each kept point, holding on output stall. Reset
//  is synchronous, active low; memory contents are not cleared. Input ready is
//  low from the final item until the last kept point has been taken.
// ----------------------------------------------------------------------------
module near_point_thinning #(
    parameter int MAX_POINTS = 64,
    parameter int MAX_DIM = 4
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [npt_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [npt_pkg::CFG_DATA_W-1:0] i_cfg_data,
    npt_in_if.sink                        i_in_ch,
    npt_out_if.source                     o_out_ch
);
    import npt_pkg::*;

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 2);
    localparam int OW = WORD_W * MAX_DIM;

    // Point storage
    t_word           mem_abs [MAX_POINTS];
    logic [OW-1:0]   mem_ord [MAX_POINTS];

    // Configuration
    logic               r_drop_dup;
    logic [RATIO_W-1:0] r_ratio;
    logic [DIM_W-1:0]   r_dims;

    // Sequencer state
    t_npt_state r_state, n_state;
    logic [CW-1:0] r_n, n_n;
    logic [CW-1:0] r_nn, n_nn;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_kept, n_kept;
    logic [CW-1:0] r_scan, n_scan;
    logic [CW-1:0] r_mv_src, n_mv_src;
    logic [CW-1:0] r_mv_dst, n_mv_dst;
    logic          r_mv_last, n_mv_last;
    logic          r_ovf, n_ovf;
    logic          r_tl_a, n_tl_a;
    t_word         r_ap, n_ap;
    t_word         r_an, n_an;
    t_word         r_ai, n_ai;
    t_word         r_ai1, n_ai1;
    t_word         r_apm, n_apm;
    logic          r_out_valid, n_out_valid;
    logic          r_out_last, n_out_last;

    // Memory ports
    logic [IW-1:0] w_raddr;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    t_word         w_wabs;
    logic [OW-1:0] w_word;
    t_word         r_rd_abs;
    logic [OW-1:0] r_rd_ord;
    logic [OW-1:0] w_in_ord;

    // Output payload
    t_word r_out_abs;
    t_word r_out_crd [NUM_COORDS];
    t_word w_em_crd [NUM_COORDS];

    // Arithmetic
    t_span w_dold, w_dnew, w_mul_span;
    t_prod w_prod;
    t_prod w_lhs_old, w_lhs_new;
    logic  w_tl_b;
    logic [CW-1:0] w_p;
    logic [DIM_W-1:0] w_dims_eff;

    // Map 1-based point number to memory address, out of range reads entry 0
    function automatic logic [IW-1:0] pt_addr(input logic [CW-1:0] k);
        logic [CW-1:0] km1;
        km1 = k - CW'(1);
        if (k == '0 || k > CW'(MAX_POINTS)) begin
            pt_addr = '0;
        end else begin
            pt_addr = km1[IW-1:0];
        end
    endfunction

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_dup <= CFG_DROP_DUP_RST;
            r_ratio    <= CFG_RATIO_RST;
            r_dims     <= CFG_DIMS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_DROP_DUP: r_drop_dup <= i_cfg_data[0];
                CFG_RATIO:    r_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_DIMS:     r_dims <= i_cfg_data[DIM_W-1:0];
                default:      r_drop_dup <= r_drop_dup;
            endcase
        end
    end

    assign w_dims_eff = (r_dims > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : r_dims;

    // Pack incoming ordinates
    always_comb begin
        w_in_ord = '0;
        w_in_ord[0 +: WORD_W] = i_in_ch.coord_a;
        if (MAX_DIM > 1) w_in_ord[WORD_W*(1 % MAX_DIM) +: WORD_W] = i_in_ch.coord_b;
        if (MAX_DIM > 2) w_in_ord[WORD_W*(2 % MAX_DIM) +: WORD_W] = i_in_ch.coord_c;
        if (MAX_DIM > 3) w_in_ord[WORD_W*(3 % MAX_DIM) +: WORD_W] = i_in_ch.coord_d;
    end

    // Span differences and ratio compares
    assign w_p = r_nn - CW'(1);
    assign w_dold = $signed({r_an[WORD_W-1], r_an}) - $signed({r_ap[WORD_W-1], r_ap});
    assign w_dnew = $signed({r_ai[WORD_W-1], r_ai}) - $signed({r_an[WORD_W-1], r_an});
    assign w_lhs_old = {{(PROD_W-SPAN_W-8){w_dold[SPAN_W-1]}}, w_dold, 8'b0};
    assign w_lhs_new = {{(PROD_W-SPAN_W-8){w_dnew[SPAN_W-1]}}, w_dnew, 8'b0};
    assign w_mul_span = (r_state == ST_RD_PM) ? w_dnew : w_dold;
    assign w_tl_b = w_lhs_new > w_prod;

    npt_ratio_mul u_mul (
        .i_clk  (i_clk),
        .i_span (w_mul_span),
        .i_ratio(r_ratio),
        .o_prod (w_prod)
    );

    // Memory: one write and one registered read
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_abs[w_waddr] <= w_wabs;
            mem_ord[w_waddr] <= w_word;
        end
        r_rd_abs <= mem_abs[w_raddr];
        r_rd_ord <= mem_ord[w_raddr];
    end

    // Select emitted ordinates
    for (genvar j = 0; j < NUM_COORDS; j++) begin : g_crd
        if (j < MAX_DIM) begin : g_used
            assign w_em_crd[j] = (DIM_W'(j) < w_dims_eff) ? r_rd_ord[WORD_W*j +: WORD_W] : '0;
        end else begin : g_zero
            assign w_em_crd[j] = '0;
        end
    end

    // Sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LOAD;
            r_n         <= '0;
            r_nn        <= '0;
            r_i         <= '0;
            r_kept      <= '0;
            r_scan      <= '0;
            r_mv_last   <= 1'b0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_nn        <= n_nn;
            r_i         <= n_i;
            r_kept      <= n_kept;
            r_scan      <= n_scan;
            r_mv_last   <= n_mv_last;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_mv_src <= n_mv_src;
        r_mv_dst <= n_mv_dst;
        r_tl_a   <= n_tl_a;
        r_ap     <= n_ap;
        r_an     <= n_an;
        r_ai     <= n_ai;
        r_ai1    <= n_ai1;
        r_apm    <= n_apm;
        r_out_last <= n_out_last;
        if (r_state == ST_EM_CAP) begin
            r_out_abs <= r_rd_abs;
            for (int j = 0; j < NUM_COORDS; j++) begin
                r_out_crd[j] <= w_em_crd[j];
            end
        end
    end

    // Next state and datapath control
    always_comb begin
        n_state     = r_state;
        n_n         = r_n;
        n_nn        = r_nn;
        n_i         = r_i;
        n_kept      = r_kept;
        n_scan      = r_scan;
        n_mv_src    = r_mv_src;
        n_mv_dst    = r_mv_dst;
        n_mv_last   = r_mv_last;
        n_ovf       = r_ovf;
        n_tl_a      = r_tl_a;
        n_ap        = r_ap;
        n_an        = r_an;
        n_ai        = r_ai;
        n_ai1       = r_ai1;
        n_apm       = r_apm;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        w_raddr     = '0;
        w_we        = 1'b0;
        w_waddr     = r_n[IW-1:0];
        w_wabs      = i_in_ch.abscissa;
        w_word      = w_in_ord;

        unique case (r_state)
            // Store points until the final one
            ST_LOAD: begin
                if (i_in_ch.valid) begin
                    if (r_n < CW'(MAX_POINTS)) begin
                        w_we = 1'b1;
                        n_n  = r_n + CW'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_ch.final_point) begin
                        n_state = ST_START;
                    end
                end
            end
            ST_START: begin
                n_nn = CW'(2);
                n_i  = CW'(3);
                if (r_n <= CW'(2)) begin
                    n_nn    = r_n;
                    n_state = ST_FINISH;
                end else begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                n_state = (r_i > r_n) ? ST_FINISH : ST_RD_P;
            end
            // Fetch the abscissas one read at a time
            ST_RD_P: begin
                w_raddr = pt_addr(w_p);
                n_state = ST_RD_N;
            end
            ST_RD_N: begin
                w_raddr = pt_addr(r_nn);
                n_ap    = r_rd_abs;
                n_state = ST_RD_I;
            end
            ST_RD_I: begin
                w_raddr = pt_addr(r_i);
                n_an    = r_rd_abs;
                n_state = ST_RD_I1;
            end
            ST_RD_I1: begin
                w_raddr = pt_addr(r_i + CW'(1));
                n_ai    = r_rd_abs;
                n_state = ST_RD_PM;
            end
            ST_RD_PM: begin
                w_raddr = pt_addr(w_p - CW'(1));
                n_ai1   = r_rd_abs;
                n_state = ST_CAP_PM;
            end
            ST_CAP_PM: begin
                n_apm   = r_rd_abs;
                n_tl_a  = w_lhs_old > w_prod;
                n_state = ST_DECIDE;
            end
            // Apply the thinning rules
            ST_DECIDE: begin
                n_state   = ST_MV_RD;
                n_mv_last = 1'b0;
                n_mv_dst  = r_nn + CW'(1);
                n_mv_src  = r_i;
                if (r_drop_dup) begin
                    if (w_dnew == '0 || r_tl_a) begin
                        if (r_i < r_n) begin
                            n_i     = r_i + CW'(1);
                            n_state = ST_CHECK;
                        end else begin
                            n_mv_dst  = r_nn;
                            n_mv_last = 1'b1;
                        end
                    end else if (w_tl_b) begin
                        if (w_p <= CW'(1)) begin
                            n_mv_dst = r_nn;
                            n_i      = r_i + CW'(1);
                        end else begin
                            n_mv_dst = w_p;
                            n_mv_src = r_nn;
                            n_nn     = w_p;
                        end
                    end else begin
                        n_nn = r_nn + CW'(1);
                        n_i  = r_i + CW'(1);
                    end
                end else begin
                    if (r_an != r_ap && r_ai != r_an && r_tl_a) begin
                        n_i = r_i + CW'(1);
                        if (r_i == r_n || r_ai == r_ai1) begin
                            n_mv_dst = r_nn;
                        end else begin
                            n_state = ST_CHECK;
                        end
                    end else if (r_an != r_ap && r_ai != r_an && w_tl_b) begin
                        if (w_p <= CW'(1) || r_ap == r_apm) begin
                            n_mv_dst = r_nn;
                            n_i      = r_i + CW'(1);
                        end else begin
                            n_mv_dst = w_p;
                            n_mv_src = r_nn;
                            n_nn     = w_p;
                        end
                    end else begin
                        n_nn = r_nn + CW'(1);
                        n_i  = r_i + CW'(1);
                    end
                end
            end
            // Copy one point over another
            ST_MV_RD: begin
                w_raddr = pt_addr(r_mv_src);
                n_state = ST_MV_WR;
            end
            ST_MV_WR: begin
                w_we    = 1'b1;
                w_waddr = pt_addr(r_mv_dst);
                w_wabs  = r_rd_abs;
                w_word  = r_rd_ord;
                n_state = r_mv_last ? ST_FINISH : ST_CHECK;
            end
            ST_FINISH: begin
                n_kept  = r_nn;
                n_scan  = '0;
                n_state = (r_nn == '0) ? ST_LOAD : ST_EM_RD;
                if (r_nn == '0) begin
                    n_n   = '0;
                    n_ovf = 1'b0;
                end
            end
            // Stream the kept points
            ST_EM_RD: begin
                w_raddr = pt_addr(r_scan + CW'(1));
                n_state = ST_EM_CAP;
            end
            ST_EM_CAP: begin
                n_out_valid = 1'b1;
                n_out_last  = (r_scan + CW'(1) == r_kept);
                n_state     = ST_EM_OUT;
            end
            ST_EM_OUT: begin
                if (o_out_ch.ready) begin
                    n_out_valid = 1'b0;
                    n_scan      = r_scan + CW'(1);
                    if (r_out_last) begin
                        n_state = ST_LOAD;
                        n_n     = '0;
                        n_kept  = '0;
                        n_scan  = '0;
                        n_ovf   = 1'b0;
                    end else begin
                        n_state = ST_EM_RD;
                    end
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    // Drive channels
    assign i_in_ch.ready          = (r_state == ST_LOAD);
    assign o_out_ch.valid         = r_out_valid;
    assign o_out_ch.kept_abscissa = r_out_abs;
    assign o_out_ch.kept_a        = r_out_crd[0];
    assign o_out_ch.kept_b        = r_out_crd[1];
    assign o_out_ch.kept_c        = r_out_crd[2];
    assign o_out_ch.kept_d        = r_out_crd[3];
    assign o_out_ch.end_of_run    = r_out_last;
    assign o_out_ch.overflowed    = r_ovf;

endmodule

FILE: rtl/core/npt_ratio_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_ratio_mul
// Shared span-by-ratio multiplier with a registered product.
// ----------------------------------------------------------------------------
module npt_ratio_mul (
    input  logic                   i_clk,
    input  npt_pkg::t_span         i_span,
    input  logic [npt_pkg::RATIO_W-1:0] i_ratio,
    output npt_pkg::t_prod         o_prod
);
    import npt_pkg::*;

    t_prod r_prod;
    t_prod n_prod;

    // Signed span times unsigned ratio
    always_comb begin
        n_prod = PROD_W'(i_span * $signed({1'b0, i_ratio}));
    end

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

    assign o_prod = r_prod;

endmodule

FILE: rtl/core/npt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// npt_checker
// Port-level checks of the near point thinning block.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module npt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_abscissa,
    input logic        out_last,
    input logic        out_ovf
);
    // Hold a stalled item
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_valid && !out_ready, out_valid && $stable(out_abscissa))
    // Never load while emitting
    `ASSERT_NOW(a_no_overlap, i_clk, i_rst_n, out_valid, !in_ready)
    // Take no input item while a kept item is offered
    `ASSERT_NOW(a_no_take, i_clk, i_rst_n, in_valid && in_ready, !out_valid)
    // Return to loading after the last kept item
    `ASSERT_NEXT(a_run_done, i_clk, i_rst_n, out_valid && out_ready && out_last, in_ready && !out_valid)
    // Overflow flag is steady through a run
    `ASSERT_NEXT(a_ovf_steady, i_clk, i_rst_n, out_valid && out_ready && !out_last, $stable(out_ovf))

endmodule

bind near_point_thinning npt_checker u_npt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .in_valid    (i_in_ch.valid),
    .in_ready    (i_in_ch.ready),
    .out_valid   (o_out_ch.valid),
    .out_ready   (o_out_ch.ready),
    .out_abscissa(o_out_ch.kept_abscissa),
    .out_last    (o_out_ch.end_of_run),
    .out_ovf     (o_out_ch.overflowed)
);
